FILE: src/mpwm_pkg.sv
// Package for the multi-pattern word matcher: sizes, register indexes,
// shared types and the character helpers.
// No dependencies.
package mpwm_pkg;

    localparam int NUM_PATTERNS  = 4;
    localparam int PATTERN_LEN   = 4;
    localparam int REPORT_LIMIT  = 11;

    localparam int CHAR_W        = 8;
    localparam int WORD_W        = 16;
    localparam int PIDX_W        = 2;
    localparam int PCOUNT_W      = 3;
    localparam int PLEN_W        = 3;
    localparam int PAT_W         = 4 * CHAR_W + PLEN_W;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = PAT_W;
    localparam int RCOUNT_W      = 4;
    localparam int HIST_DEPTH    = PATTERN_LEN - 1;
    localparam int HIST_LEN_W    = $clog2(PATTERN_LEN);
    localparam int QDEPTH        = 4;
    localparam int QPTR_W        = $clog2(QDEPTH);
    localparam int QCNT_W        = QPTR_W + 1;

    localparam logic [WORD_W-1:0]   WORD_MAX   = {WORD_W{1'b1}};
    localparam logic [RCOUNT_W-1:0] RLIMIT     = RCOUNT_W'(REPORT_LIMIT);
    localparam logic [PCOUNT_W-1:0] PCOUNT_MAX = PCOUNT_W'(NUM_PATTERNS);

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_A     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_B     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_C     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_D     = 3'd4;

    // input command codes
    localparam logic CMD_CHAR     = 1'b0;
    localparam logic CMD_END_WORD = 1'b1;

    typedef logic [PAT_W-1:0] t_pattern;

    typedef struct packed {
        logic [PCOUNT_W-1:0]               pattern_count;
        logic [NUM_PATTERNS-1:0][PAT_W-1:0] patterns;
    } t_cfg;

    typedef struct packed {
        logic [NUM_PATTERNS-1:0] mask;
        logic [WORD_W-1:0]       word;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // fold A-Z to lower case, leave every other code alone
    function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
        if (c >= 8'd65 && c <= 8'd90) begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic logic is_punct(input logic [CHAR_W-1:0] c);
        return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

endpackage

FILE: src/multi_pattern_word_matcher_core.sv
// Top level of the multi-pattern word matcher: configuration registers,
// input register, scan logic and result queue. Depends on mpwm_pkg,
// mpwm_scan and mpwm_queue.
//
//  channel  direction  handshake                    payload
//  in       to core    i_in_valid / o_in_ready      i_cmd, i_ch
//  out      from core  o_out_valid / i_out_ready    o_pattern_index, o_word_number, o_last
//  cfg      to core    i_cfg_we (no wait)           i_cfg_index, i_cfg_data
//
// An item is taken into the input register and scanned against all patterns
// once the result queue has room; its matches land in that four-entry queue:
// one item per cycle while the queue is not full. The queue hands out one
// match per cycle while the output port is ready, so items with several
// matches slow the input only once the queue fills and the output port sets the pace.
// Reset (synchronous, active low) clears the word state, report counts and
// configuration; no clearing pass is needed.
module multi_pattern_word_matcher_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mpwm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mpwm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_cmd,
    input  logic [mpwm_pkg::CHAR_W-1:0]       i_ch,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [mpwm_pkg::PIDX_W-1:0]       o_pattern_index,
    output logic [mpwm_pkg::WORD_W-1:0]       o_word_number,
    output logic                              o_last
);
    import mpwm_pkg::*;

    t_cfg              r_cfg, n_cfg;
    logic              r_in_valid, n_in_valid;
    logic              r_cmd;
    logic [CHAR_W-1:0] r_ch;

    logic              w_fire, w_accept;
    t_entry            w_entry;
    t_queue_status     w_qstat;

    // write configuration registers; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PATTERN_COUNT: n_cfg.pattern_count = i_cfg_data[PCOUNT_W-1:0];
                REG_PATTERN_A:     n_cfg.patterns[0]   = i_cfg_data[PAT_W-1:0];
                REG_PATTERN_B:     n_cfg.patterns[1]   = i_cfg_data[PAT_W-1:0];
                REG_PATTERN_C:     n_cfg.patterns[2]   = i_cfg_data[PAT_W-1:0];
                REG_PATTERN_D:     n_cfg.patterns[3]   = i_cfg_data[PAT_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    // scan the held item when the queue has room
    assign w_fire     = r_in_valid && !w_qstat.full;
    assign o_in_ready = !r_in_valid || w_fire;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_fire) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= '0;
            r_in_valid <= 1'b0;
        end else begin
            r_cfg      <= n_cfg;
            r_in_valid <= n_in_valid;
        end
    end

    // hold the accepted item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd;
            r_ch  <= i_ch;
        end
    end

    mpwm_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_fire  (w_fire),
        .i_cmd   (r_cmd),
        .i_ch    (r_ch),
        .o_entry (w_entry)
    );

    mpwm_queue u_queue (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (w_fire && (w_entry.mask != '0)),
        .i_entry         (w_entry),
        .o_status        (w_qstat),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_pattern_index (o_pattern_index),
        .o_word_number   (o_word_number),
        .o_last          (o_last)
    );

`ifndef NO_ASSERTIONS
    a_fire_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |-> r_in_valid)
        else $error("scan fired without a held item");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_fire) |=> r_in_valid)
        else $error("held item lost while the queue was full");

    a_empty_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.empty |-> !o_out_valid)
        else $error("result shown while the queue is empty");
`endif

endmodule

FILE: src/mpwm_scan.sv
// Word and segment tracking, character history and the parallel pattern
// compares for one registered item. Depends on mpwm_pkg.
module mpwm_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mpwm_pkg::t_cfg                i_cfg,
    input  logic                          i_fire,
    input  logic                          i_cmd,
    input  logic [mpwm_pkg::CHAR_W-1:0]   i_ch,
    output mpwm_pkg::t_entry              o_entry
);
    import mpwm_pkg::*;

    logic [HIST_DEPTH-1:0][CHAR_W-1:0] r_hist, n_hist;
    logic [HIST_LEN_W-1:0]             r_hist_len, n_hist_len;
    logic [WORD_W-1:0]                 r_word, n_word;
    logic                              r_in_word, n_in_word;
    logic                              r_split_done, n_split_done;
    logic                              r_split_pending, n_split_pending;
    logic [NUM_PATTERNS-1:0][RCOUNT_W-1:0] r_counts, n_counts;

    logic [CHAR_W-1:0]       w_c;
    logic                    w_sd, w_sp, w_split_now, w_bump;
    logic [HIST_LEN_W-1:0]   w_hlen;
    logic [WORD_W-1:0]       w_word;
    logic [PCOUNT_W-1:0]     w_active;
    logic [NUM_PATTERNS-1:0] w_hit;

    // effective segment state once a new word has been opened
    always_comb begin
        w_c         = to_lower(i_ch);
        w_sd        = r_in_word & r_split_done;
        w_sp        = r_in_word & r_split_pending;
        w_hlen      = r_in_word ? r_hist_len : '0;
        w_split_now = (i_cmd == CMD_CHAR) && !w_sd && is_punct(w_c);
        if (i_cmd == CMD_END_WORD) begin
            w_bump = r_in_word & r_split_pending;
        end else begin
            w_bump = !r_in_word || (w_sp && !w_split_now);
        end
        w_word   = (w_bump && r_word != WORD_MAX) ? r_word + 1'b1 : r_word;
        w_active = (i_cfg.pattern_count > PCOUNT_MAX) ? PCOUNT_MAX : i_cfg.pattern_count;
    end

    // compare every pattern against the current character and history
    always_comb begin
        logic [PLEN_W-1:0] len;
        logic [CHAR_W-1:0] pc, tc;
        logic [1:0]        pos;
        logic              ok;
        for (int j = 0; j < NUM_PATTERNS; j++) begin
            len = i_cfg.patterns[j][PAT_W-1 -: PLEN_W];
            ok  = (len != '0) && (len <= PLEN_W'(PATTERN_LEN)) && (len <= 3'd4) &&
                  ({1'b0, PLEN_W'(w_hlen)} + 4'd1 >= {1'b0, len});
            for (int k = 0; k < PATTERN_LEN; k++) begin
                pos = 2'(len - 3'd1 - 3'(k));
                pc  = to_lower(i_cfg.patterns[j][pos*CHAR_W +: CHAR_W]);
                tc  = (k == 0) ? w_c : r_hist[(k == 0) ? 0 : k - 1];
                if (3'(k) < len && pc != tc) begin
                    ok = 1'b0;
                end
            end
            w_hit[j] = ok && (i_cmd == CMD_CHAR) && !w_split_now &&
                       (PCOUNT_W'(j) < w_active) && (r_counts[j] < RLIMIT);
        end
    end

    assign o_entry.mask = w_hit;
    assign o_entry.word = w_word;

    // next segment state
    always_comb begin
        n_hist          = r_hist;
        n_hist_len      = r_hist_len;
        n_word          = r_word;
        n_in_word       = r_in_word;
        n_split_done    = r_split_done;
        n_split_pending = r_split_pending;
        n_counts        = r_counts;
        if (i_fire) begin
            n_word = w_word;
            if (i_cmd == CMD_END_WORD) begin
                n_in_word       = 1'b0;
                n_split_done    = 1'b0;
                n_split_pending = 1'b0;
                n_hist_len      = '0;
            end else if (w_split_now) begin
                n_in_word       = 1'b1;
                n_split_done    = 1'b1;
                n_split_pending = 1'b1;
                n_hist_len      = '0;
            end else begin
                n_in_word       = 1'b1;
                n_split_done    = w_sd;
                n_split_pending = 1'b0;
                for (int k = HIST_DEPTH - 1; k > 0; k--) begin
                    n_hist[k] = r_hist[k-1];
                end
                n_hist[0]  = w_c;
                n_hist_len = (w_hlen < HIST_LEN_W'(HIST_DEPTH)) ? w_hlen + 1'b1 : w_hlen;
                for (int j = 0; j < NUM_PATTERNS; j++) begin
                    if (w_hit[j]) begin
                        n_counts[j] = r_counts[j] + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist          <= '0;
            r_hist_len      <= '0;
            r_word          <= '0;
            r_in_word       <= 1'b0;
            r_split_done    <= 1'b0;
            r_split_pending <= 1'b0;
            r_counts        <= '0;
        end else begin
            r_hist          <= n_hist;
            r_hist_len      <= n_hist_len;
            r_word          <= n_word;
            r_in_word       <= n_in_word;
            r_split_done    <= n_split_done;
            r_split_pending <= n_split_pending;
            r_counts        <= n_counts;
        end
    end

endmodule

FILE: src/mpwm_queue.sv
// Result queue: holds match masks with their word number and hands out one
// match per ready cycle in rising pattern order. Depends on mpwm_pkg.
module mpwm_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  mpwm_pkg::t_entry              i_entry,
    output mpwm_pkg::t_queue_status       o_status,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mpwm_pkg::PIDX_W-1:0]   o_pattern_index,
    output logic [mpwm_pkg::WORD_W-1:0]   o_word_number,
    output logic                          o_last
);
    import mpwm_pkg::*;

    t_entry                  r_mem [QDEPTH];
    logic [QPTR_W-1:0]       r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]       r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]       r_count, n_count;
    logic [NUM_PATTERNS-1:0] r_done, n_done;

    t_entry                  w_head;
    logic [NUM_PATTERNS-1:0] w_rem, w_pick;
    logic [PIDX_W-1:0]       w_idx;
    logic                    w_pop, w_take;

    assign o_status.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_status.empty = (r_count == '0);

    // pick the lowest pattern still owed by the head entry
    always_comb begin
        w_head = r_mem[r_rd_ptr];
        w_rem  = w_head.mask & ~r_done;
        w_pick = '0;
        w_idx  = '0;
        for (int j = NUM_PATTERNS - 1; j >= 0; j--) begin
            if (w_rem[j]) begin
                w_pick = NUM_PATTERNS'(1) << j;
                w_idx  = PIDX_W'(j);
            end
        end
    end

    assign o_valid         = !o_status.empty;
    assign o_pattern_index = w_idx;
    assign o_word_number   = w_head.word;
    assign o_last          = ((w_rem & ~w_pick) == '0);

    assign w_take = o_valid && i_ready;
    assign w_pop  = w_take && o_last;

    // advance pointers, count and the per-entry done bits
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + QCNT_W'(i_push) - QCNT_W'(w_pop);
        if (w_pop) begin
            n_done = '0;
        end else if (w_take) begin
            n_done = r_done | w_pick;
        end else begin
            n_done = r_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_done   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
            r_done   <= n_done;
        end
    end

    // store entries; payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("result queue count above depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("push into a full result queue");

    a_head_owes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (w_rem != '0))
        else $error("head entry has no match left to report");

    a_done_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (r_done == '0))
        else $error("done bits not cleared after the last match of an entry");
`endif

endmodule

FILE: tb/tb_multi_pattern_word_matcher_core.sv
// Testbench for multi_pattern_word_matcher_core: streams characters and word ends,
// predicts every pattern match in a scoreboard class and checks the result port.
// Depends on mpwm_pkg and the core RTL.
module tb_multi_pattern_word_matcher_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mpwm_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_PCT      = 15;
    localparam int PRINT_CAP     = 200;
    localparam int PHASES        = 6;
    localparam int RANDOM_ITEMS  = 240;
    localparam int TAIL_WORDS    = 8;

    // configuration indexes past the register list
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [PIDX_W-1:0] pattern_index;
        logic [WORD_W-1:0] word_number;
        logic              last;
    } t_match;

    // Predicts the matches of each accepted item and checks results in order
    class match_board;
        logic [PCOUNT_W-1:0] pat_count;
        logic [PAT_W-1:0]    pat_regs [NUM_PATTERNS];
        logic [CHAR_W-1:0]   recent [HIST_DEPTH];
        int                  recent_len;
        logic [WORD_W-1:0]   word_num;
        bit                  in_word;
        bit                  split_done;
        bit                  split_pending;
        int                  reports [NUM_PATTERNS];
        t_match              expected_matches [$];
        int                  mismatches;

        function new();
            pat_count     = '0;
            recent_len    = 0;
            word_num      = '0;
            in_word       = 0;
            split_done    = 0;
            split_pending = 0;
            mismatches    = 0;
            foreach (pat_regs[j]) pat_regs[j] = '0;
            foreach (reports[j]) reports[j] = 0;
            foreach (recent[k]) recent[k] = '0;
        endfunction

        function logic [CHAR_W-1:0] fold_case(logic [CHAR_W-1:0] c);
            return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
        endfunction

        function bit splits_word(logic [CHAR_W-1:0] c);
            return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
                   (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
        endfunction

        function void bump_word();
            if (word_num != WORD_MAX) word_num++;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_PATTERN_COUNT) begin
                pat_count = data[PCOUNT_W-1:0];
            end else if (idx >= REG_PATTERN_A && idx <= REG_PATTERN_D) begin
                pat_regs[idx - REG_PATTERN_A] = data;
            end
        endfunction

        // true when the pattern ends at the current (lowered) character
        function bit ends_here(logic [PAT_W-1:0] pat, logic [CHAR_W-1:0] c);
            int                len;
            logic [CHAR_W-1:0] want;
            logic [CHAR_W-1:0] got;
            len = int'(pat[PAT_W-1 -: PLEN_W]);
            if (len == 0 || len > PATTERN_LEN) return 0;
            if (recent_len < len - 1) return 0;
            for (int k = 0; k < len; k++) begin
                want = fold_case(pat[CHAR_W*(len-1-k) +: CHAR_W]);
                if (k == 0) begin
                    got = c;
                end else begin
                    got = recent[k-1];
                end
                if (want != got) return 0;
            end
            return 1;
        endfunction

        function void predict_item(logic cmd, logic [CHAR_W-1:0] ch_in);
            logic [CHAR_W-1:0] c;
            int                active;
            int                n_hits;
            int                pushed;
            bit                hit [NUM_PATTERNS];
            t_match            m;
            c = fold_case(ch_in);

            // close the word; a split at its end still uses up a number
            if (cmd == CMD_END_WORD) begin
                if (in_word && split_pending) bump_word();
                in_word       = 0;
                split_done    = 0;
                split_pending = 0;
                recent_len    = 0;
                return;
            end

            if (!in_word) begin
                bump_word();
                in_word       = 1;
                split_done    = 0;
                split_pending = 0;
                recent_len    = 0;
            end

            // first punctuation mark splits the word and matches nothing
            if (!split_done && splits_word(c)) begin
                split_done    = 1;
                split_pending = 1;
                recent_len    = 0;
                return;
            end

            if (split_pending) begin
                bump_word();
                split_pending = 0;
            end

            active = (pat_count > NUM_PATTERNS) ? NUM_PATTERNS : int'(pat_count);
            n_hits = 0;
            for (int j = 0; j < NUM_PATTERNS; j++) begin
                hit[j] = (j < active) && ends_here(pat_regs[j], c) &&
                         (reports[j] < REPORT_LIMIT);
                if (hit[j]) n_hits++;
            end
            pushed = 0;
            for (int j = 0; j < NUM_PATTERNS; j++) begin
                if (hit[j]) begin
                    reports[j]++;
                    pushed++;
                    m.pattern_index = PIDX_W'(j);
                    m.word_number   = word_num;
                    m.last          = (pushed == n_hits);
                    expected_matches.push_back(m);
                end
            end

            // shift the character into the segment history
            for (int k = HIST_DEPTH - 1; k > 0; k--) recent[k] = recent[k-1];
            recent[0] = c;
            if (recent_len < HIST_DEPTH) recent_len++;
        endfunction

        task report_mismatch(string msg);
            if (mismatches < PRINT_CAP) $display("MISMATCH at %0t ns: %s", $time, msg);
            mismatches++;
        endtask

        task check_match(logic [PIDX_W-1:0] pidx, logic [WORD_W-1:0] wnum, logic lst);
            t_match want;
            if (expected_matches.size() == 0) begin
                report_mismatch($sformatf("unexpected match: pattern %0d word %0d last %0b",
                                          pidx, wnum, lst));
                return;
            end
            want = expected_matches.pop_front();
            if (pidx !== want.pattern_index)
                report_mismatch($sformatf("pattern_index %0d, wanted %0d",
                                          pidx, want.pattern_index));
            if (wnum !== want.word_number)
                report_mismatch($sformatf("word_number %0d, wanted %0d (pattern %0d)",
                                          wnum, want.word_number, want.pattern_index));
            if (lst !== want.last)
                report_mismatch($sformatf("last %0b, wanted %0b (pattern %0d word %0d)",
                                          lst, want.last, want.pattern_index,
                                          want.word_number));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_cmd;
    logic [CHAR_W-1:0]     i_ch;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [PIDX_W-1:0]     o_pattern_index;
    logic [WORD_W-1:0]     o_word_number;
    logic                  o_last;

    match_board board;
    bit         calm;
    int         items_sent;
    int         cycle_count;

    multi_pattern_word_matcher_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_ch            (i_ch),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pattern_index (o_pattern_index),
        .o_word_number   (o_word_number),
        .o_last          (o_last)
    );

    always #5 i_clk = ~i_clk;

    // end the run if it hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // stall the result port at random
    always @(negedge i_clk) begin
        i_out_ready <= !take_break();
    end

    // check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1)
            board.check_match(o_pattern_index, o_word_number, o_last);
    end

    function automatic logic [CHAR_W-1:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 65) begin
            case ($urandom_range(4))
                0: return "a";
                1: return "A";
                2: return "b";
                3: return "B";
                default: return "c";
            endcase
        end
        if (r < 80) begin
            case ($urandom_range(3))
                0: return ".";
                1: return "!";
                2: return "~";
                default: return "@";
            endcase
        end
        return CHAR_W'($urandom_range(255));
    endfunction

    function automatic logic [CHAR_W-1:0] ab_char();
        case ($urandom_range(4))
            0: return "a";
            1: return "A";
            2: return "b";
            3: return "B";
            default: return ".";
        endcase
    endfunction

    // mostly short patterns over the text alphabet, sometimes raw bits
    function automatic logic [PAT_W-1:0] random_pattern();
        logic [PAT_W-1:0] p;
        p[31:0]        = $urandom;
        p[PAT_W-1:32]  = PLEN_W'($urandom);
        if ($urandom_range(9) < 8) begin
            for (int k = 0; k < 4; k++) p[CHAR_W*k +: CHAR_W] = pick_char();
            p[PAT_W-1:32] = PLEN_W'($urandom_range(4, 1));
        end
        return p;
    endfunction

    // a pattern whose length can never match
    function automatic logic [PAT_W-1:0] dead_pattern();
        logic [PLEN_W-1:0] len;
        len = ($urandom_range(3) == 0) ? PLEN_W'(0) : PLEN_W'($urandom_range(7, 5));
        return {len, 32'($urandom)};
    endfunction

    // hold the item until accepted, idling before it at random
    task automatic send_item(logic cmd, logic [CHAR_W-1:0] ch);
        @(negedge i_clk);
        if (take_break()) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while (take_break());
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_ch       <= ch;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        board.predict_item(cmd, ch);
        items_sent++;
    endtask

    // a space in the text stands for the end of a word
    task automatic send_words(string s);
        for (int i = 0; i < s.len(); i++) begin
            if (s[i] == " ") begin
                send_item(CMD_END_WORD, 8'h20);
            end else begin
                send_item(CMD_CHAR, s[i]);
            end
        end
    endtask

    task automatic send_random_word(bit ab_only);
        int n;
        n = ab_only ? $urandom_range(8, 3) : $urandom_range(6, 1);
        for (int i = 0; i < n; i++) send_item(CMD_CHAR, ab_only ? ab_char() : pick_char());
        send_item(CMD_END_WORD, CHAR_W'($urandom));
    endtask

    task automatic load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        board.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // drop valid, wait for all matches, then let the pipeline empty
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.expected_matches.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [PCOUNT_W-1:0] phase_counts [PHASES];
        int                  stop_at;

        board       = new();
        calm        = 0;
        items_sent  = 0;
        cycle_count = 0;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_cmd       = CMD_CHAR;
        i_ch        = '0;
        i_out_ready = 1'b0;
        phase_counts = '{3'd4, 3'd2, 3'd7, 3'd0, 3'd5, 3'd3};

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: case folding, splits, one-char words, stray end, byte extremes
        load_reg(REG_PATTERN_COUNT, CFG_DATA_W'(3));
        load_reg(REG_PATTERN_A, {3'd2, 16'h0, "b", "A"});
        load_reg(REG_PATTERN_B, {3'd1, 24'h0, "B"});
        load_reg(REG_PATTERN_C, {3'd3, 8'h00, "Z", 8'hFF, 8'h00});
        load_reg(REG_PATTERN_D, {3'd5, 32'h6162_6364});
        send_words("aB !ab a.b x, b ");
        send_item(CMD_END_WORD, 8'hFF);
        send_words("a b ");
        send_item(CMD_CHAR, 8'h00);
        send_item(CMD_CHAR, 8'hFF);
        send_item(CMD_CHAR, "Z");
        send_item(CMD_END_WORD, 8'h00);
        settle();

        // random phases: pattern 3 stays dead to keep its report budget
        for (int ph = 0; ph < PHASES; ph++) begin
            calm = (ph == 2);
            load_reg(REG_PATTERN_COUNT, CFG_DATA_W'(phase_counts[ph]));
            load_reg(REG_PATTERN_A, random_pattern());
            load_reg(REG_PATTERN_B, random_pattern());
            load_reg(REG_PATTERN_C, random_pattern());
            load_reg(REG_PATTERN_D, dead_pattern());
            load_reg(CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)),
                     random_pattern());
            stop_at = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < stop_at) begin
                if ($urandom_range(9) == 0) begin
                    send_item(CMD_END_WORD, CHAR_W'($urandom));
                end else begin
                    send_random_word(0);
                end
            end
            settle();
        end
        calm = 0;

        // all patterns on, pattern 3 four characters long
        load_reg(REG_PATTERN_COUNT, CFG_DATA_W'(7));
        load_reg(REG_PATTERN_D, {3'd4, "b", "A", "b", "a"});
        load_reg(REG_PATTERN_A, {3'd1, 24'h0, "a"});
        for (int w = 0; w < TAIL_WORDS; w++) send_random_word(1);
        settle();

        if (board.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: multi_pattern_word_matcher_core.f
src/mpwm_pkg.sv
src/mpwm_scan.sv
src/mpwm_queue.sv
src/multi_pattern_word_matcher_core.sv
tb/tb_multi_pattern_word_matcher_core.sv
